>>> rtl/ssed_pkg.sv
`timescale 1ns / 1ps
package ssed_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int NUM_LANES   = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int SCALE_BITS  = 6;
  localparam int COORD_BITS  = 10;
  localparam int SIZE_BITS   = 11;

  localparam logic [11:0] WIDTH_CAP  = 12'(MAX_WIDTH);
  localparam logic [11:0] HEIGHT_CAP = 12'(MAX_HEIGHT);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CONTRAST     = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_FIRST_COLUMN = 3'd3,
    REG_END_COLUMN   = 3'd4,
    REG_FIRST_ROW    = 3'd5,
    REG_END_ROW      = 3'd6,
    REG_SCALE_LABEL  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]           peak_floor;
    logic [COORD_BITS-1:0] first_column;
    logic [COORD_BITS-1:0] end_column;
    logic [COORD_BITS-1:0] first_row;
    logic [COORD_BITS-1:0] end_row;
  } bounds_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 clr;
    logic                 shift;
  } lane_ctrl_t;

  function automatic logic [11:0] clamp_size(logic [SIZE_BITS-1:0] v, logic [11:0] hi);
    logic [11:0] ve;
    ve = {1'b0, v};
    if (ve < 12'd3) begin
      return 12'd3;
    end
    if (ve > hi) begin
      return hi;
    end
    return ve;
  endfunction

endpackage

>>> rtl/ssed_pix_if.sv
`timescale 1ns / 1ps
interface ssed_pix_if;
  logic                valid;
  logic                ready;
  ssed_pkg::sample_t   level_below;
  ssed_pkg::sample_t   level_middle;
  ssed_pkg::sample_t   level_above;

  modport source (output valid, output level_below, output level_middle,
                  output level_above, input ready);
  modport sink   (input valid, input level_below, input level_middle,
                  input level_above, output ready);
endinterface

>>> rtl/ssed_kp_if.sv
`timescale 1ns / 1ps
interface ssed_kp_if;
  logic                                 valid;
  logic                                 ready;
  logic [ssed_pkg::SCALE_BITS-1:0]      kp_scale;
  logic [ssed_pkg::COORD_BITS-1:0]      kp_column;
  logic [ssed_pkg::COORD_BITS-1:0]      kp_row;

  modport source (output valid, output kp_scale, output kp_column, output kp_row,
                  input ready);
  modport sink   (input valid, input kp_scale, input kp_column, input kp_row,
                  output ready);
endinterface

>>> rtl/ssed_plane_lane.sv
`timescale 1ns / 1ps
module ssed_plane_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssed_pkg::lane_ctrl_t ctrl_i,
  input  ssed_pkg::sample_t    pix_i,
  input  ssed_pkg::sample_t    centre_i,
  output ssed_pkg::sample_t    centre_o,
  output logic                 not_less_o
);

  // each entry: {two rows above, one row above}
  logic [2*ssed_pkg::SAMPLE_BITS-1:0] mem [ssed_pkg::MAX_WIDTH];
  logic [2*ssed_pkg::SAMPLE_BITS-1:0] rd_r;
  ssed_pkg::sample_t                  pix_r;
  ssed_pkg::sample_t                  win_r [3][2];
  ssed_pkg::sample_t                  col3 [3];
  logic [2*ssed_pkg::SAMPLE_BITS-1:0] wr_data;

  always_comb begin
    col3[0] = rd_r[2*ssed_pkg::SAMPLE_BITS-1:ssed_pkg::SAMPLE_BITS];
    col3[1] = rd_r[ssed_pkg::SAMPLE_BITS-1:0];
    col3[2] = pix_r;
    wr_data = ctrl_i.clr ? '0 : {col3[1], col3[2]};
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_r  <= mem[ctrl_i.rd_addr];
      pix_r <= pix_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= '0;
        win_r[k][1] <= '0;
      end
    end else if (ctrl_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= col3[k];
      end
    end
  end

  assign centre_o = win_r[1][1];

  always_comb begin
    not_less_o = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (win_r[k][0] > centre_i || win_r[k][1] > centre_i || col3[k] > centre_i) begin
        not_less_o = 1'b0;
      end
    end
  end

endmodule

>>> rtl/ssed_merge.sv
`timescale 1ns / 1ps
module ssed_merge (
  input  logic [ssed_pkg::NUM_LANES-1:0]  lane_ok_i,
  input  ssed_pkg::sample_t               centre_i,
  input  logic [ssed_pkg::ADDR_BITS-1:0]  col_i,
  input  logic [ssed_pkg::ROW_BITS-1:0]   row_i,
  input  ssed_pkg::bounds_t               bounds_i,
  output logic                            found_o,
  output logic [ssed_pkg::COORD_BITS-1:0] kp_column_o,
  output logic [ssed_pkg::COORD_BITS-1:0] kp_row_o
);

  logic [ssed_pkg::ADDR_BITS-1:0] cc;
  logic [ssed_pkg::ROW_BITS-1:0]  cr;
  logic                           full;
  logic                           in_bounds;

  always_comb begin
    cc        = col_i - ssed_pkg::ADDR_BITS'(1);
    cr        = row_i - ssed_pkg::ROW_BITS'(1);
    full      = (col_i >= ssed_pkg::ADDR_BITS'(2)) && (row_i >= ssed_pkg::ROW_BITS'(2));
    in_bounds = (cc >= bounds_i.first_column) && (cc < bounds_i.end_column) &&
                (cr >= bounds_i.first_row) && (cr < bounds_i.end_row);
    found_o   = full && in_bounds && (&lane_ok_i) &&
                (centre_i > bounds_i.peak_floor);
    kp_column_o = ssed_pkg::COORD_BITS'(cc);
    kp_row_o    = ssed_pkg::COORD_BITS'(cr);
  end

endmodule

>>> rtl/scale_space_extremum_detector.sv
`timescale 1ns / 1ps
// three plane lanes and their line stores work in parallel; a keypoint passes the
// stage-1 and output registers; throughput: one pixel per cycle while in_pix.ready is high
// in_pix.ready is low in the clearing pass, or if a keypoint waits and another is found
// reset: synchronous active-low; afterwards the line stores are zeroed one column a cycle,
// with in_pix.ready low; configuration writes are taken at any time
module scale_space_extremum_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ssed_pix_if.sink                             in_pix,
  ssed_kp_if.source                            out_kp,
  input  logic                                 cfg_we,
  input  logic [ssed_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ssed_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  ssed_pkg::bounds_t                  bounds_r;
  logic [ssed_pkg::SIZE_BITS-1:0]     image_width_r;
  logic [ssed_pkg::SIZE_BITS-1:0]     image_height_r;
  logic [ssed_pkg::SCALE_BITS-1:0]    scale_label_r;

  logic                               clr_r;
  logic [ssed_pkg::ADDR_BITS-1:0]     clr_cnt_r;

  logic [ssed_pkg::ADDR_BITS-1:0]     col_r;
  logic [ssed_pkg::ROW_BITS-1:0]      row_r;
  logic [ssed_pkg::ADDR_BITS-1:0]     col_nxt;
  logic [ssed_pkg::ROW_BITS-1:0]      row_nxt;

  logic                               s1_valid_r;
  logic [ssed_pkg::ADDR_BITS-1:0]     s1_col_r;
  logic [ssed_pkg::ROW_BITS-1:0]      s1_row_r;

  logic                               out_valid_r;
  logic [ssed_pkg::SCALE_BITS-1:0]    out_scale_r;
  logic [ssed_pkg::COORD_BITS-1:0]    out_column_r;
  logic [ssed_pkg::COORD_BITS-1:0]    out_row_r;

  logic                               in_fire;
  logic                               s1_fire;
  logic                               found;
  logic [ssed_pkg::COORD_BITS-1:0]    kp_column;
  logic [ssed_pkg::COORD_BITS-1:0]    kp_row;
  logic [11:0]                        w_eff;
  logic [11:0]                        h_eff;
  logic [ssed_pkg::ADDR_BITS:0]       col_inc;
  logic [ssed_pkg::ROW_BITS:0]        row_inc;

  ssed_pkg::lane_ctrl_t               lane_ctrl;
  ssed_pkg::sample_t                  lane_pix   [ssed_pkg::NUM_LANES];
  ssed_pkg::sample_t                  lane_centre[ssed_pkg::NUM_LANES];
  logic [ssed_pkg::NUM_LANES-1:0]     lane_ok;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.peak_floor   <= '0;
      bounds_r.first_column <= ssed_pkg::COORD_BITS'(1);
      bounds_r.end_column   <= ssed_pkg::COORD_BITS'(1023);
      bounds_r.first_row    <= ssed_pkg::COORD_BITS'(1);
      bounds_r.end_row      <= ssed_pkg::COORD_BITS'(1023);
      image_width_r         <= ssed_pkg::SIZE_BITS'(1024);
      image_height_r        <= ssed_pkg::SIZE_BITS'(1024);
      scale_label_r         <= ssed_pkg::SCALE_BITS'(1);
    end else if (cfg_we) begin
      case (ssed_pkg::reg_idx_t'(cfg_index))
        ssed_pkg::REG_CONTRAST:     bounds_r.peak_floor <= cfg_data[15:0];
        ssed_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[ssed_pkg::SIZE_BITS-1:0];
        ssed_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[ssed_pkg::SIZE_BITS-1:0];
        ssed_pkg::REG_FIRST_COLUMN: bounds_r.first_column <= cfg_data[ssed_pkg::COORD_BITS-1:0];
        ssed_pkg::REG_END_COLUMN:   bounds_r.end_column   <= cfg_data[ssed_pkg::COORD_BITS-1:0];
        ssed_pkg::REG_FIRST_ROW:    bounds_r.first_row    <= cfg_data[ssed_pkg::COORD_BITS-1:0];
        ssed_pkg::REG_END_ROW:      bounds_r.end_row      <= cfg_data[ssed_pkg::COORD_BITS-1:0];
        ssed_pkg::REG_SCALE_LABEL:  scale_label_r  <= cfg_data[ssed_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // line store clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + ssed_pkg::ADDR_BITS'(1);
      if (clr_cnt_r == ssed_pkg::ADDR_BITS'(ssed_pkg::MAX_WIDTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // handshake
  always_comb begin
    s1_fire      = s1_valid_r && (!found || !out_valid_r || out_kp.ready);
    in_pix.ready = !clr_r && (!s1_valid_r || s1_fire);
    in_fire      = in_pix.valid && in_pix.ready;
  end

  // raster position
  always_comb begin
    w_eff   = ssed_pkg::clamp_size(image_width_r, ssed_pkg::WIDTH_CAP);
    h_eff   = ssed_pkg::clamp_size(image_height_r, ssed_pkg::HEIGHT_CAP);
    col_inc = {1'b0, col_r} + (ssed_pkg::ADDR_BITS + 1)'(1);
    row_inc = {1'b0, row_r} + (ssed_pkg::ROW_BITS + 1)'(1);
    col_nxt = col_inc[ssed_pkg::ADDR_BITS-1:0];
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ssed_pkg::ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // plane lanes: below, middle, above
  always_comb begin
    lane_ctrl.rd_en   = in_fire;
    lane_ctrl.rd_addr = col_r;
    lane_ctrl.wr_en   = s1_fire || clr_r;
    lane_ctrl.wr_addr = clr_r ? clr_cnt_r : s1_col_r;
    lane_ctrl.clr     = clr_r;
    lane_ctrl.shift   = s1_fire;
    lane_pix[0]       = in_pix.level_below;
    lane_pix[1]       = in_pix.level_middle;
    lane_pix[2]       = in_pix.level_above;
  end

  for (genvar g = 0; g < ssed_pkg::NUM_LANES; g++) begin : g_lane
    ssed_plane_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (lane_ctrl),
      .pix_i      (lane_pix[g]),
      .centre_i   (lane_centre[1]),
      .centre_o   (lane_centre[g]),
      .not_less_o (lane_ok[g])
    );
  end

  ssed_merge u_merge (
    .lane_ok_i   (lane_ok),
    .centre_i    (lane_centre[1]),
    .col_i       (s1_col_r),
    .row_i       (s1_row_r),
    .bounds_i    (bounds_r),
    .found_o     (found),
    .kp_column_o (kp_column),
    .kp_row_o    (kp_row)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && found) begin
      out_valid_r <= 1'b1;
    end else if (out_kp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && found) begin
      out_scale_r  <= scale_label_r;
      out_column_r <= kp_column;
      out_row_r    <= kp_row;
    end
  end

  assign out_kp.valid     = out_valid_r;
  assign out_kp.kp_scale  = out_scale_r;
  assign out_kp.kp_column = out_column_r;
  assign out_kp.kp_row    = out_row_r;

endmodule
